[rtl/variable_record_lifo_stack_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the variable record LIFO stack
// Shared property wrappers, clocked on clk_i and idle during reset.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_LIFO_STACK_MACROS_SVH
`define VARIABLE_RECORD_LIFO_STACK_MACROS_SVH

// Same-cycle implication.
`define VRLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VRLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vrls_pkg.sv]
// ---------------------------------------------------------------------------
// vrls_pkg
// Types and constants shared by the record stack front, back and top level.
// ---------------------------------------------------------------------------
package vrls_pkg;

  localparam int unsigned BYTE_W                   = 8;
  localparam int unsigned LEN_W                    = 7;
  localparam int unsigned DEF_STORE_BYTES          = 4096;
  localparam int unsigned DEF_TRAILER_BYTES        = 4;
  localparam int unsigned DEF_MAX_RECORD_BYTES     = 64;
  localparam int unsigned CMD_DEPTH                = 2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRAIL,
    S_TRL,
    S_STREAM
  } bstate_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len_c;
    logic [LEN_W-1:0]  want;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              out_last;
    status_e           status;
    logic              is_empty;
  } res_t;

endpackage

[rtl/vrls_front.sv]
// ---------------------------------------------------------------------------
// vrls_front
// Accepts items, clamps the announced length and queues decoded commands.
// ---------------------------------------------------------------------------
module vrls_front #(
  parameter int unsigned MAX_RECORD_BYTES = vrls_pkg::DEF_MAX_RECORD_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  op_i,
  input  logic [vrls_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [vrls_pkg::LEN_W-1:0]  record_length_i,
  input  logic                        last_byte_i,
  output vrls_pkg::cmd_t              cmd_o,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i
);

  localparam logic [vrls_pkg::LEN_W-1:0] MaxLen = vrls_pkg::LEN_W'(MAX_RECORD_BYTES);

  vrls_pkg::cmd_t cmd_q [vrls_pkg::CMD_DEPTH];
  vrls_pkg::cmd_t dec;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           wr_en, rd_en;

  // Classify the item and clamp the announced length to 1..max.
  always_comb begin
    dec.op    = vrls_pkg::op_e'(op_i);
    dec.data  = data_byte_i;
    dec.want  = record_length_i;
    dec.last  = last_byte_i;
    if (record_length_i == '0) begin
      dec.len_c = vrls_pkg::LEN_W'(1);
    end else if (record_length_i > MaxLen) begin
      dec.len_c = MaxLen;
    end else begin
      dec.len_c = record_length_i;
    end
  end

  assign full        = (cnt_q == 2'(vrls_pkg::CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmd_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

[rtl/vrls_back.sv]
// ---------------------------------------------------------------------------
// vrls_back
// Executes commands against the byte store and holds the result register.
// ---------------------------------------------------------------------------
module vrls_back #(
  parameter int unsigned STORE_BYTES      = vrls_pkg::DEF_STORE_BYTES,
  parameter int unsigned TRAILER_BYTES    = vrls_pkg::DEF_TRAILER_BYTES,
  parameter int unsigned MAX_RECORD_BYTES = vrls_pkg::DEF_MAX_RECORD_BYTES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vrls_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  output vrls_pkg::res_t res_o,
  output logic           res_valid_o,
  input  logic           res_pop_i
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned TW = $clog2(STORE_BYTES + 1);
  localparam int unsigned SW = TW + 1;
  localparam int unsigned LW = vrls_pkg::LEN_W;
  localparam int unsigned BW = vrls_pkg::BYTE_W;
  localparam logic [SW-1:0] StoreS = SW'(STORE_BYTES);
  localparam logic [TW-1:0] TrlT   = TW'(TRAILER_BYTES);
  localparam logic [LW-1:0] MaxL   = LW'(MAX_RECORD_BYTES);

  logic [BW-1:0] mem [STORE_BYTES];
  logic [BW-1:0] rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [BW-1:0] wdata;

  vrls_pkg::bstate_e state_q, state_d;
  logic [TW-1:0] top_q, top_d;
  logic          in_rec_q, in_rec_d, drop_q, drop_d, pop_q, pop_d;
  logic [LW-1:0] rbw_q, rbw_d, idx_q, idx_d, n_q, n_d;
  logic [AW-1:0] trl_addr_q, trl_addr_d, addr_q, addr_d;
  logic [BW-1:0] trl_val_q, trl_val_d;
  logic          out_valid_q, can_load, load;
  vrls_pkg::res_t res_q, res_d;

  logic [SW-1:0] sum_new, sum_grow;
  logic [TW-1:0] pos, avail, start;
  logic [LW-1:0] s1, stored, n;

  assign can_load = !out_valid_q || res_pop_i;
  assign sum_new  = SW'(top_q) + SW'(cmd_i.len_c) + SW'(TrlT);
  assign sum_grow = SW'(top_q) + SW'(rbw_q) + SW'(1) + SW'(TrlT);
  assign pos      = top_q + TW'(rbw_q);
  assign avail    = top_q - TrlT;
  assign s1       = (rdata_q > BW'(MaxL)) ? MaxL : rdata_q[LW-1:0];
  assign stored   = (TW'(s1) > avail) ? avail[LW-1:0] : s1;
  assign start    = avail - TW'(stored);
  assign n        = (stored < n_q) ? stored : n_q;

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    in_rec_d    = in_rec_q;
    drop_d      = drop_q;
    pop_d       = pop_q;
    rbw_d       = rbw_q;
    idx_d       = idx_q;
    n_d         = n_q;
    trl_addr_d  = trl_addr_q;
    trl_val_d   = trl_val_q;
    addr_d      = addr_q;
    we          = 1'b0;
    waddr       = pos[AW-1:0];
    wdata       = cmd_i.data;
    re          = 1'b0;
    raddr       = avail[AW-1:0];
    load        = 1'b0;
    cmd_ready_o = 1'b0;
    res_d       = '{out_byte: '0, has_byte: 1'b0, out_last: 1'b1,
                    status: vrls_pkg::ST_OK, is_empty: 1'b0};
    case (state_q)
      vrls_pkg::S_IDLE: begin
        if (cmd_valid_i && can_load) begin
          cmd_ready_o = 1'b1;
          if (cmd_i.op != vrls_pkg::OP_PUSH) begin
            in_rec_d = 1'b0;
            drop_d   = 1'b0;
            rbw_d    = '0;
          end
          case (cmd_i.op)
            vrls_pkg::OP_PUSH: begin
              load = 1'b1;
              if (drop_q) begin
                if (cmd_i.last) drop_d = 1'b0;
                res_d.status = vrls_pkg::ST_FULL;
              end else if (!in_rec_q) begin
                if (sum_new >= StoreS) begin
                  drop_d       = !cmd_i.last;
                  res_d.status = vrls_pkg::ST_FULL;
                end else begin
                  we = 1'b1;
                  if (cmd_i.last) begin
                    trl_addr_d = AW'(top_q + TW'(1));
                    trl_val_d  = BW'(1);
                    top_d      = top_q + TW'(1) + TrlT;
                    state_d    = vrls_pkg::S_TRAIL;
                  end else begin
                    in_rec_d = 1'b1;
                    rbw_d    = LW'(1);
                  end
                end
              end else if (rbw_q >= MaxL || sum_grow >= StoreS) begin
                // close with the bytes held, reject this one
                we           = 1'b1;
                wdata        = BW'(rbw_q);
                top_d        = pos + TrlT;
                in_rec_d     = 1'b0;
                rbw_d        = '0;
                drop_d       = !cmd_i.last;
                res_d.status = vrls_pkg::ST_FULL;
              end else begin
                we = 1'b1;
                if (cmd_i.last) begin
                  trl_addr_d = AW'(pos + TW'(1));
                  trl_val_d  = BW'(rbw_q) + BW'(1);
                  top_d      = pos + TW'(1) + TrlT;
                  in_rec_d   = 1'b0;
                  rbw_d      = '0;
                  state_d    = vrls_pkg::S_TRAIL;
                end else begin
                  rbw_d = rbw_q + LW'(1);
                end
              end
              res_d.is_empty = (top_d == '0);
            end
            vrls_pkg::OP_CLEAR: begin
              load           = 1'b1;
              top_d          = '0;
              res_d.is_empty = 1'b1;
            end
            default: begin
              if (top_q < TrlT) begin
                load           = 1'b1;
                top_d          = '0;
                res_d.status   = vrls_pkg::ST_EMPTY;
                res_d.is_empty = 1'b1;
              end else begin
                re      = 1'b1;
                n_d     = cmd_i.want;
                pop_d   = (cmd_i.op == vrls_pkg::OP_POP);
                state_d = vrls_pkg::S_TRL;
              end
            end
          endcase
        end
      end
      vrls_pkg::S_TRAIL: begin
        we      = 1'b1;
        waddr   = trl_addr_q;
        wdata   = trl_val_q;
        state_d = vrls_pkg::S_IDLE;
      end
      vrls_pkg::S_TRL: begin
        if (n == '0) begin
          if (can_load) begin
            load = 1'b1;
            if (pop_q) top_d = start;
            res_d.is_empty = (top_d == '0);
            state_d = vrls_pkg::S_IDLE;
          end
        end else begin
          if (pop_q) top_d = start;
          re      = 1'b1;
          raddr   = start[AW-1:0];
          addr_d  = start[AW-1:0];
          idx_d   = '0;
          n_d     = n;
          state_d = vrls_pkg::S_STREAM;
        end
      end
      vrls_pkg::S_STREAM: begin
        if (can_load) begin
          load           = 1'b1;
          res_d.out_byte = rdata_q;
          res_d.has_byte = 1'b1;
          res_d.out_last = (idx_q + LW'(1) == n_q);
          res_d.is_empty = (top_q == '0);
          if (res_d.out_last) begin
            state_d = vrls_pkg::S_IDLE;
          end else begin
            re     = 1'b1;
            raddr  = addr_q + AW'(1);
            addr_d = addr_q + AW'(1);
            idx_d  = idx_q + LW'(1);
          end
        end
      end
      default: state_d = vrls_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    trl_addr_q <= trl_addr_d;
    trl_val_q  <= trl_val_d;
    addr_q     <= addr_d;
    idx_q      <= idx_d;
    n_q        <= n_d;
    pop_q      <= pop_d;
    if (load) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrls_pkg::S_IDLE;
      top_q       <= '0;
      in_rec_q    <= 1'b0;
      drop_q      <= 1'b0;
      rbw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      in_rec_q <= in_rec_d;
      drop_q   <= drop_d;
      rbw_q    <= rbw_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = out_valid_q;

endmodule

[rtl/variable_record_lifo_stack.sv]
// ---------------------------------------------------------------------------
// variable_record_lifo_stack
// LIFO of variable-length byte records with length trailers in a byte store.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Fields
// items     in         push / full          op, data_byte, record_length, last_byte
// results   out        empty / pop          out_byte, has_byte, out_last, status,
//                                           is_empty
//
// Push, clear and rejected items complete in the idle state; a push that closes
// a record then writes the length trailer through the single store write port.
// Pop and peek first fetch the trailer, then return one byte per cycle while the
// result register is free, paced by the store's registered read port.
// Reset empties the stack at once; the store itself needs no clearing.
// A held result stalls the back end only; the front queue keeps taking items
// until its two entries are full.
// ---------------------------------------------------------------------------
module variable_record_lifo_stack #(
  parameter int unsigned STORE_BYTES      = vrls_pkg::DEF_STORE_BYTES,
  parameter int unsigned TRAILER_BYTES    = vrls_pkg::DEF_TRAILER_BYTES,
  parameter int unsigned MAX_RECORD_BYTES = vrls_pkg::DEF_MAX_RECORD_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item side
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  op_i,
  input  logic [vrls_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [vrls_pkg::LEN_W-1:0]  record_length_i,
  input  logic                        last_byte_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic [vrls_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        has_byte_o,
  output logic                        out_last_o,
  output logic [1:0]                  status_o,
  output logic                        is_empty_o
);

  vrls_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready;
  vrls_pkg::res_t res;
  logic           res_valid;

  // Front: classify and queue each transfer.
  vrls_front #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .record_length_i(record_length_i),
    .last_byte_i    (last_byte_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready)
  );

  // Back: own the store and stack pointer, stream results.
  vrls_back #(
    .STORE_BYTES     (STORE_BYTES),
    .TRAILER_BYTES   (TRAILER_BYTES),
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .res_o      (res),
    .res_valid_o(res_valid),
    .res_pop_i  (pop)
  );

  // Present the single held result; empty is high while no result is held.
  assign empty      = !res_valid;
  assign out_byte_o = res.out_byte;
  assign has_byte_o = res.has_byte;
  assign out_last_o = res.out_last;
  assign status_o   = res.status;
  assign is_empty_o = res.is_empty;

endmodule

[rtl/vrls_checker.sv]
// ---------------------------------------------------------------------------
// vrls_checker
// Port-level checks on the record stack results, bound to the top level.
// ---------------------------------------------------------------------------
`include "variable_record_lifo_stack_macros.svh"

module vrls_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       out_last_o,
  input logic [1:0] status_o,
  input logic       is_empty_o
);

  `VRLS_ASSERT_NOW(a_empty_status, !empty && status_o == 2'd1, is_empty_o, "empty status with data")
  `VRLS_ASSERT_NOW(a_reject_single, !empty && status_o == 2'd2, !has_byte_o && out_last_o, "reject not single")
  `VRLS_ASSERT_NOW(a_data_ok, !empty && has_byte_o, status_o == 2'd0, "data with bad status")
  `VRLS_ASSERT_NOW(a_nodata_zero, !empty && !has_byte_o, out_byte_o == 8'd0, "stray byte")
  `VRLS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte_o), "held result changed")

endmodule

bind variable_record_lifo_stack vrls_checker u_vrls_checker (.*);

[verif/variable_record_lifo_stack_tb.sv]
// ---------------------------------------------------------------------------
// Record stack testbench
// Drives push/pop/peek/clear transfers into the variable record LIFO stack
// and checks every result against a behavioral model of the stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module variable_record_lifo_stack_tb;

  localparam int unsigned STORE_BYTES = 4096;
  localparam int unsigned TRAILER_BYTES = 4;
  localparam int unsigned MAX_REC = 64;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] op_i = vrls_pkg::OP_PUSH;
  logic [vrls_pkg::BYTE_W-1:0] data_byte_i = '0;
  logic [vrls_pkg::LEN_W-1:0] record_length_i = '0;
  logic last_byte_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [vrls_pkg::BYTE_W-1:0] out_byte_o;
  logic has_byte_o;
  logic out_last_o;
  logic [1:0] status_o;
  logic is_empty_o;

  // Typed expectation that rides along with the item being offered.
  logic typed_valid = 1'b0;
  vrls_pkg::res_t typed_res = '0;

  variable_record_lifo_stack dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .op_i(op_i), .data_byte_i(data_byte_i),
    .record_length_i(record_length_i), .last_byte_i(last_byte_i),
    .empty(empty), .pop(pop),
    .out_byte_o(out_byte_o), .has_byte_o(has_byte_o), .out_last_o(out_last_o),
    .status_o(status_o), .is_empty_o(is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // Stack model: its own copy of the byte store and record pointers
  // ------------------------------------------------------------------
  logic [7:0] stack_mem [STORE_BYTES];
  int unsigned stack_top;
  bit open_rec;
  bit dropping;
  int unsigned open_len;
  vrls_pkg::res_t expected_results[$];
  int unsigned error_count = 0;
  int idle_phase = 0;  // 0: sender 28 / receiver 49, 1: swapped, 2: no idling

  function automatic void add_result(logic [7:0] b, bit has, bit last,
                                     vrls_pkg::status_e st);
    vrls_pkg::res_t r;
    r.out_byte = b;
    r.has_byte = has;
    r.out_last = last;
    r.status = st;
    r.is_empty = (stack_top == 0);
    expected_results.push_back(r);
  endfunction

  function automatic void seal_record();
    int unsigned base;
    int unsigned v;
    base = stack_top + open_len;
    v = open_len;
    for (int i = 0; i < TRAILER_BYTES; i++) begin
      if (base + i < STORE_BYTES) stack_mem[base + i] = v[7:0];
      v = v >> 8;
    end
    stack_top = base + TRAILER_BYTES;
    open_rec = 1'b0;
    open_len = 0;
  endfunction

  function automatic void stack_push(logic [7:0] b, int unsigned len, bit last);
    if (dropping) begin
      if (last) dropping = 1'b0;
      add_result(8'h00, 1'b0, 1'b1, vrls_pkg::ST_FULL);
      return;
    end
    if (!open_rec) begin
      if (len < 1) len = 1;
      if (len > MAX_REC) len = MAX_REC;
      if (stack_top + len + TRAILER_BYTES >= STORE_BYTES) begin
        dropping = !last;
        add_result(8'h00, 1'b0, 1'b1, vrls_pkg::ST_FULL);
        return;
      end
      open_rec = 1'b1;
      open_len = 0;
    end else if (open_len >= MAX_REC ||
                 stack_top + open_len + 1 + TRAILER_BYTES >= STORE_BYTES) begin
      seal_record();
      dropping = !last;
      add_result(8'h00, 1'b0, 1'b1, vrls_pkg::ST_FULL);
      return;
    end
    stack_mem[stack_top + open_len] = b;
    open_len++;
    if (last) seal_record();
    add_result(8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK);
  endfunction

  function automatic void stack_read(int unsigned want, bit discard);
    int unsigned stored;
    int unsigned start;
    int unsigned n;
    if (stack_top < TRAILER_BYTES) begin
      stack_top = 0;
      add_result(8'h00, 1'b0, 1'b1, vrls_pkg::ST_EMPTY);
      return;
    end
    stored = 0;
    for (int i = TRAILER_BYTES - 1; i >= 0; i--)
      stored = (stored << 8) | 32'(stack_mem[stack_top - TRAILER_BYTES + i]);
    if (stored > MAX_REC) stored = MAX_REC;
    if (stored > stack_top - TRAILER_BYTES) stored = stack_top - TRAILER_BYTES;
    start = stack_top - TRAILER_BYTES - stored;
    n = (stored < want) ? stored : want;
    if (discard) stack_top = start;
    if (n == 0) begin
      add_result(8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK);
      return;
    end
    for (int i = 0; i < n; i++)
      add_result(stack_mem[start + i], 1'b1, (i + 1 == n), vrls_pkg::ST_OK);
  endfunction

  function automatic void predict_item(vrls_pkg::op_e op, logic [7:0] b, logic [6:0] len,
                                       bit last);
    if (op == vrls_pkg::OP_PUSH) begin
      stack_push(b, 32'(len), last);
      return;
    end
    // Any other op abandons a partial record and any dropping.
    open_rec = 1'b0;
    dropping = 1'b0;
    open_len = 0;
    if (op == vrls_pkg::OP_CLEAR) begin
      stack_top = 0;
      add_result(8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK);
    end else begin
      stack_read(32'(len), op == vrls_pkg::OP_POP);
    end
  endfunction

  // Record the expectations of every accepted input transfer.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      predict_item(vrls_pkg::op_e'(op_i), data_byte_i, record_length_i, last_byte_i);
      if (typed_valid) begin
        // Rows with a hand-written answer replace the single model result.
        void'(expected_results.pop_back());
        expected_results.push_back(typed_res);
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Compare each accepted result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    vrls_pkg::res_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", int'(out_byte_o), 0);
      end else begin
        e = expected_results.pop_front();
        if (out_byte_o !== e.out_byte)
          report_mismatch("out_byte", int'(out_byte_o), int'(e.out_byte));
        if (has_byte_o !== e.has_byte)
          report_mismatch("has_byte", int'(has_byte_o), int'(e.has_byte));
        if (out_last_o !== e.out_last)
          report_mismatch("out_last", int'(out_last_o), int'(e.out_last));
        if (status_o !== e.status)
          report_mismatch("status", int'(status_o), int'(e.status));
        if (is_empty_o !== e.is_empty)
          report_mismatch("is_empty", int'(is_empty_o), int'(e.is_empty));
      end
    end
  end

  // Receiver: random pop idling, plus one long hold-off so the stack backs up.
  int unsigned hold_cnt = 0;
  bit hold_done = 0;
  always @(posedge clk_i) begin
    int unsigned idle_pct;
    idle_pct = (idle_phase == 0) ? 49 : (idle_phase == 1) ? 28 : 0;
    if (!hold_done && idle_phase == 1) begin
      hold_done <= 1'b1;
      hold_cnt <= 500;
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Timeout guard.
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------
  // Offer one item and return at the edge where it transfers; push stays
  // high so that a following item can go out back to back.
  task automatic send_item(vrls_pkg::op_e op, logic [7:0] b, logic [6:0] len, bit last,
                           bit use_typed = 1'b0, vrls_pkg::res_t tr = '0);
    int unsigned idle_pct;
    idle_pct = (idle_phase == 0) ? 28 : (idle_phase == 1) ? 49 : 0;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    data_byte_i <= b;
    record_length_i <= len;
    last_byte_i <= last;
    typed_valid <= use_typed;
    typed_res <= tr;
    // Hold the item until a transfer happens at an edge with full low.
    do @(posedge clk_i); while (full);
  endtask

  // Push a record of nbytes, announcing ann as its length.
  task automatic send_record(int unsigned nbytes, int unsigned ann);
    for (int i = 0; i < nbytes; i++)
      send_item(vrls_pkg::OP_PUSH, 8'($urandom_range(255)), 7'(ann), i + 1 == nbytes);
  endtask

  task automatic random_items(int unsigned count);
    int unsigned sel;
    int unsigned n;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(MAX_REC, 1) : $urandom_range(8, 1);
        send_record(n, ($urandom_range(3) == 0) ? $urandom_range(127) : n);
      end else if (sel < 72) begin
        send_item(vrls_pkg::OP_POP, 8'($urandom_range(255)), 7'($urandom_range(127)),
                  1'($urandom_range(1)));
      end else if (sel < 84) begin
        send_item(vrls_pkg::OP_PEEK, 8'($urandom_range(255)), 7'($urandom_range(127)),
                  1'($urandom_range(1)));
      end else if (sel < 88) begin
        send_item(vrls_pkg::OP_CLEAR, 8'($urandom_range(255)), 7'($urandom_range(127)),
                  1'($urandom_range(1)));
      end else begin
        // Noise: loose push bytes that may leave a record open.
        send_item(vrls_pkg::OP_PUSH, 8'($urandom_range(255)), 7'($urandom_range(127)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  typedef struct {
    vrls_pkg::op_e op;
    logic [7:0] b;
    logic [6:0] len;
    bit last;
    bit typed;
    vrls_pkg::res_t r;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    // read on an empty stack
    '{vrls_pkg::OP_POP,   8'h00, 7'd5,   1'b0, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_EMPTY, 1'b1}},
    '{vrls_pkg::OP_PEEK,  8'hFF, 7'd5,   1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_EMPTY, 1'b1}},
    // announced length zero is clamped to one
    '{vrls_pkg::OP_PUSH,  8'hA5, 7'd0,   1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK,    1'b0}},
    // zero bytes requested
    '{vrls_pkg::OP_PEEK,  8'h00, 7'd0,   1'b0, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK,    1'b0}},
    '{vrls_pkg::OP_PEEK,  8'h00, 7'd127, 1'b0, 1'b1,
      '{8'hA5, 1'b1, 1'b1, vrls_pkg::ST_OK,    1'b0}},
    '{vrls_pkg::OP_PUSH,  8'h00, 7'd64,  1'b0, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK,    1'b0}},
    '{vrls_pkg::OP_PUSH,  8'hFF, 7'd1,   1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK,    1'b0}},
    '{vrls_pkg::OP_PEEK,  8'h00, 7'd1,   1'b0, 1'b1,
      '{8'h00, 1'b1, 1'b1, vrls_pkg::ST_OK,    1'b0}},
    '{vrls_pkg::OP_POP,   8'h00, 7'd127, 1'b0, 1'b0, '0},
    '{vrls_pkg::OP_POP,   8'h00, 7'd0,   1'b0, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK,    1'b1}},
    '{vrls_pkg::OP_POP,   8'h00, 7'd3,   1'b0, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_EMPTY, 1'b1}},
    // clear abandons an open record
    '{vrls_pkg::OP_PUSH,  8'h11, 7'd3,   1'b0, 1'b0, '0},
    '{vrls_pkg::OP_CLEAR, 8'hFF, 7'd127, 1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_OK,    1'b1}},
    // a read abandons an open record
    '{vrls_pkg::OP_PUSH,  8'h22, 7'd2,   1'b0, 1'b0, '0},
    '{vrls_pkg::OP_PEEK,  8'h00, 7'd9,   1'b0, 1'b1,
      '{8'h00, 1'b0, 1'b1, vrls_pkg::ST_EMPTY, 1'b1}},
    '{vrls_pkg::OP_PUSH,  8'h33, 7'd2,   1'b0, 1'b0, '0},
    '{vrls_pkg::OP_PUSH,  8'h44, 7'd2,   1'b1, 1'b0, '0},
    '{vrls_pkg::OP_POP,   8'h00, 7'd2,   1'b0, 1'b0, '0}
  };

  initial begin
    int unsigned wait_cycles;
    stack_top = 0;
    open_rec = 1'b0;
    dropping = 1'b0;
    open_len = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].b, directed_rows[i].len,
                directed_rows[i].last, directed_rows[i].typed, directed_rows[i].r);

    // Record that grows past its maximum size: the 65th byte is rejected.
    send_record(66, 64);
    send_item(vrls_pkg::OP_POP, 8'h00, 7'd64, 1'b0);

    idle_phase = 0;
    random_items(25);
    idle_phase = 1;
    random_items(25);
    idle_phase = 2;
    random_items(13);
    push <= 1'b0;

    // Drain: everything expected must arrive, then let the pipe settle.
    wait_cycles = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    while (wait_cycles < DRAIN_CYCLES) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/vrls_pkg.sv
rtl/vrls_front.sv
rtl/vrls_back.sv
rtl/variable_record_lifo_stack.sv
rtl/vrls_checker.sv
verif/variable_record_lifo_stack_tb.sv
